// ===== hdl/atrm_pkg.sv =====
// ----------------------------------------------------------------------------
// atrm_pkg: shared types and constants of the AT response matcher
// Action and outcome codes, match patterns, field widths and match step functions.
// ----------------------------------------------------------------------------
`default_nettype none

package atrm_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned TimeoutW = 26;
  localparam int unsigned ActionW  = 2;
  localparam int unsigned OutcomeW = 2;

  // Input tdata: rx_byte, timeout_us, padded to whole bytes.
  localparam int unsigned InDataW  = ((ByteW + TimeoutW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((OutcomeW + 7) / 8) * 8;

  typedef enum logic [ActionW-1:0] {
    ACT_ARM  = 2'd0,
    ACT_BYTE = 2'd1,
    ACT_TICK = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef enum logic [OutcomeW-1:0] {
    OUT_OK      = 2'd0,
    OUT_ERR     = 2'd1,
    OUT_RESTART = 2'd2,
    OUT_TIMEOUT = 2'd3
  } outcome_e;

  // Pattern lengths, sized to the progress counters.
  localparam logic [2:0] OkLen  = 3'd4;
  localparam logic [2:0] ErrLen = 3'd5;
  localparam logic [3:0] RstLen = 4'd9;

  // Patterns, entry 0 is the first character.
  localparam logic [3:0][7:0] OkPat  = {8'h0A, 8'h0D, 8'h4B, 8'h4F};         // OK\r\n
  localparam logic [4:0][7:0] ErrPat = {8'h0A, 8'h0D, 8'h52, 8'h52, 8'h45}; // ERR\r\n
  localparam logic [8:0][7:0] RstPat = {8'h50, 8'h53, 8'h45, 8'h54, 8'h52,
                                        8'h41, 8'h54, 8'h53, 8'h2B};         // +STARTESP

  typedef struct packed {
    logic [2:0] ok;
    logic [2:0] err;
    logic [3:0] rst;
  } progress_t;

  function automatic logic [2:0] ok_advance(logic [2:0] prog, logic [7:0] c);
    logic [2:0] nxt;
    if (prog < OkLen && c == OkPat[prog[1:0]]) begin
      nxt = prog + 3'd1;
    end else if (c == OkPat[0]) begin
      nxt = 3'd1;
    end else begin
      nxt = 3'd0;
    end
    return nxt;
  endfunction

  function automatic logic [2:0] err_advance(logic [2:0] prog, logic [7:0] c);
    logic [2:0] nxt;
    if (prog < ErrLen && c == ErrPat[prog]) begin
      nxt = prog + 3'd1;
    end else if (c == ErrPat[0]) begin
      nxt = 3'd1;
    end else begin
      nxt = 3'd0;
    end
    return nxt;
  endfunction

  function automatic logic [3:0] rst_advance(logic [3:0] prog, logic [7:0] c);
    logic [3:0] nxt;
    if (prog < RstLen && c == RstPat[prog]) begin
      nxt = prog + 4'd1;
    end else if (c == RstPat[0]) begin
      nxt = 4'd1;
    end else begin
      nxt = 4'd0;
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/at_response_matcher.sv =====
// ----------------------------------------------------------------------------
// at_response_matcher: modem reply matcher with microsecond deadline
// Arms on a start request, matches OK / ERR / restart banner on received
// bytes and reports the first match or a timeout.
// ----------------------------------------------------------------------------
// Stages: the input stage holds the request, the result register drives m_axis.
// Throughput: one request per cycle; the input stage stalls only when it
//   holds a request that yields a result while the result register is full.
// Reset: asynchronous, active low; clears the wait flag, all match progress,
//   the tick counter and both stage valid flags.
`default_nettype none

module at_response_matcher (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,

  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [7:0] rx_byte, [33:8] timeout_us, [39:34] zero
  input  wire logic [atrm_pkg::InDataW-1:0]  s_axis_tdata,
  // [1:0] action
  input  wire logic [atrm_pkg::ActionW-1:0]  s_axis_tuser,

  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [1:0] outcome, [7:2] zero
  output logic [atrm_pkg::OutDataW-1:0]      m_axis_tdata
);

  // Input stage: hold one accepted request.
  logic                                in_valid_q;
  logic [atrm_pkg::ActionW-1:0]        in_action_q;
  logic [atrm_pkg::ByteW-1:0]          in_byte_q;
  logic [atrm_pkg::TimeoutW-1:0]       in_timeout_q;

  // Matcher state.
  logic                                waiting_q, waiting_d;
  atrm_pkg::progress_t                 prog_q, prog_d;
  logic [atrm_pkg::TimeoutW-1:0]       ticks_q, ticks_d;

  // Result register.
  logic                                out_valid_q;
  logic [atrm_pkg::OutcomeW-1:0]       out_code_q;

  logic                                has_result;
  logic [atrm_pkg::OutcomeW-1:0]       result_code;
  logic                                out_free;
  logic                                proc_fire;
  atrm_pkg::progress_t                 prog_step;

  // Result slot is free if empty or being drained this cycle.
  assign out_free  = !out_valid_q || m_axis_tready;
  // Process the held request unless it needs the result slot and that is busy.
  assign proc_fire = in_valid_q && (!has_result || out_free);
  assign s_axis_tready = !in_valid_q || proc_fire;

  // Advance all three matchers on the held byte.
  assign prog_step.ok  = atrm_pkg::ok_advance(prog_q.ok, in_byte_q);
  assign prog_step.err = atrm_pkg::err_advance(prog_q.err, in_byte_q);
  assign prog_step.rst = atrm_pkg::rst_advance(prog_q.rst, in_byte_q);

  always_comb begin
    waiting_d   = waiting_q;
    prog_d      = prog_q;
    ticks_d     = ticks_q;
    has_result  = 1'b0;
    result_code = atrm_pkg::OUT_OK;
    unique case (atrm_pkg::action_e'(in_action_q))
      atrm_pkg::ACT_ARM: begin
        // Restart the wait, drop any partial match.
        waiting_d = 1'b1;
        prog_d    = '0;
        ticks_d   = in_timeout_q;
      end
      atrm_pkg::ACT_BYTE: begin
        if (waiting_q) begin
          prog_d = prog_step;
          // Check order: OK, then ERR, then restart banner.
          if (prog_step.ok >= atrm_pkg::OkLen) begin
            has_result  = 1'b1;
            result_code = atrm_pkg::OUT_OK;
            waiting_d   = 1'b0;
          end else if (prog_step.err >= atrm_pkg::ErrLen) begin
            has_result  = 1'b1;
            result_code = atrm_pkg::OUT_ERR;
            waiting_d   = 1'b0;
          end else if (prog_step.rst >= atrm_pkg::RstLen) begin
            has_result  = 1'b1;
            result_code = atrm_pkg::OUT_RESTART;
            waiting_d   = 1'b0;
          end
        end
      end
      atrm_pkg::ACT_TICK: begin
        if (waiting_q) begin
          // Expire on the tick that finds the counter already at zero.
          if (ticks_q == '0) begin
            has_result  = 1'b1;
            result_code = atrm_pkg::OUT_TIMEOUT;
            waiting_d   = 1'b0;
          end else begin
            ticks_d = ticks_q - atrm_pkg::TimeoutW'(1);
          end
        end
      end
      default: begin
        // Unused action code: ignore.
      end
    endcase
  end

  // Control: stage valids and matcher state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      waiting_q   <= 1'b0;
      prog_q      <= '0;
      ticks_q     <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (proc_fire) begin
        waiting_q <= waiting_d;
        prog_q    <= prog_d;
        ticks_q   <= ticks_d;
      end
      if (proc_fire && has_result) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: capture request and result fields.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_action_q  <= s_axis_tuser;
      in_byte_q    <= s_axis_tdata[atrm_pkg::ByteW-1:0];
      in_timeout_q <= s_axis_tdata[atrm_pkg::ByteW +: atrm_pkg::TimeoutW];
    end
    if (proc_fire && has_result) begin
      out_code_q <= result_code;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = atrm_pkg::OutDataW'(out_code_q);

endmodule

`default_nettype wire
